/* hw/rtl/tms_pkg.sv */
`default_nettype none

package tms_pkg;

  // Default depth of the note position counter.
  localparam int MAX_NOTES_DEF = 64;

  localparam int SONG_W     = 4;
  localparam int NOTE_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int LEFT_W     = 7;
  localparam int SONG_COUNT = 10;
  localparam int ROM_SIZE   = 79;
  localparam int ROM_AW     = $clog2(ROM_SIZE);

  // Result item as handed from the sequencer core to the output register.
  typedef struct packed {
    logic              tone_gate;
    logic [NOTE_W-1:0] note_code;
    logic              note_load;
    logic              tone_running;
    logic              busy_res;
  } tms_res_t;

  // On-length and off-length picked by one nibble of the tempo byte.
  localparam logic [COUNT_W-1:0] TEMPO_TABLE [16] = '{
    8'd0, 8'd4, 8'd8, 8'd12, 8'd16, 8'd20, 8'd24, 8'd28,
    8'd32, 8'd36, 8'd40, 8'd48, 8'd96, 8'd144, 8'd192, 8'd240
  };

  // First note entry of each song.
  localparam logic [ROM_AW-1:0] SONG_OFFSET [SONG_COUNT] = '{
    7'd0, 7'd3, 7'd4, 7'd7, 7'd10, 7'd12, 7'd61, 7'd63, 7'd69, 7'd75
  };

  // Number of notes in each song.
  localparam logic [LEFT_W-1:0] SONG_LENGTH [SONG_COUNT] = '{
    7'd3, 7'd1, 7'd3, 7'd3, 7'd2, 7'd49, 7'd2, 7'd6, 7'd6, 7'd4
  };

  // Melody store: note code in bits 11..8, tempo byte in bits 7..0.
  localparam logic [11:0] MELODY_ROM [ROM_SIZE] = '{
    12'hC12, 12'hC15, 12'hC1F,
    12'hA1F,
    12'h446, 12'h246, 12'h02F,
    12'h022, 12'h222, 12'h41F,
    12'h723, 12'hA1F,
    12'h222, 12'h422, 12'h426, 12'h222, 12'h422, 12'h426, 12'h522, 12'h522,
    12'h522, 12'h522, 12'h529, 12'h422, 12'h422, 12'h422, 12'h422, 12'h322,
    12'h322, 12'h322, 12'h322, 12'h222, 12'h222, 12'h222, 12'h222, 12'h229,
    12'h222, 12'h422, 12'h440, 12'h422,
    12'h222, 12'h422, 12'h426,
    12'h524, 12'h502, 12'h222, 12'h222, 12'h429,
    12'h322, 12'h322, 12'h322, 12'h322, 12'h222, 12'h222, 12'h222, 12'h222,
    12'h122, 12'h122, 12'h422, 12'h422, 12'h02F,
    12'hB22, 12'hD1F,
    12'h221, 12'h321, 12'h421, 12'h521, 12'h621, 12'h74F,
    12'h722, 12'h822, 12'h923, 12'h722, 12'h822, 12'h923,
    12'hC12, 12'hC12, 12'hC12, 12'hC13
  };

  // Note entry of a song at a position; zero past the end of the song.
  function automatic logic [11:0] note_entry(input logic [SONG_W-1:0] song,
                                             input logic [7:0]        pos);
    logic [11:0]       entry;
    logic [ROM_AW-1:0] addr;
    entry = '0;
    addr  = '0;
    if (int'(song) < SONG_COUNT) begin
      if (pos < 8'(SONG_LENGTH[song])) begin
        addr = ROM_AW'(8'(SONG_OFFSET[song]) + pos);
        if (int'(addr) < ROM_SIZE) begin
          entry = MELODY_ROM[addr];
        end
      end
    end
    return entry;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tms_in_if.sv */
`default_nettype none

interface tms_in_if;
  import tms_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [SONG_W-1:0] song;

  modport source (output valid, output mode, output song, input ready);
  modport sink   (input valid, input mode, input song, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tms_out_if.sv */
`default_nettype none

interface tms_out_if;
  import tms_pkg::*;

  logic              valid;
  logic              ready;
  logic              tone_gate;
  logic [NOTE_W-1:0] note_code;
  logic              note_load;
  logic              tone_running;
  logic              busy_res;

  modport source (output valid, output tone_gate, output note_code, output note_load,
                  output tone_running, output busy_res, input ready);
  modport sink   (input valid, input tone_gate, input note_code, input note_load,
                  input tone_running, input busy_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/tms_core.sv */
`default_nettype none

module tms_core #(
  parameter int MAX_NOTES = tms_pkg::MAX_NOTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      accept,
  input  wire logic                      mode,
  input  wire logic [tms_pkg::SONG_W-1:0] song,
  output tms_pkg::tms_res_t              res
);
  import tms_pkg::*;

  localparam int PW = $clog2(MAX_NOTES);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  phase_t              phase, phase_next;
  logic [COUNT_W-1:0]  on_count, on_count_next;
  logic [COUNT_W-1:0]  off_count, off_count_next;
  logic [PW-1:0]       note_position, note_position_next;
  logic [LEFT_W-1:0]   notes_left, notes_left_next;
  logic [SONG_W-1:0]   current_song, current_song_next;
  logic [NOTE_W-1:0]   last_note, last_note_next;
  logic                generator_on, generator_on_next;
  logic                load;
  logic [11:0]         entry;

  // The note entry for the current song and position.
  assign entry = note_entry(current_song, 8'(note_position));

  // Next state for one item: a play restarts, a tick advances the phase.
  always_comb begin
    phase_next         = phase;
    on_count_next      = on_count;
    off_count_next     = off_count;
    note_position_next = note_position;
    notes_left_next    = notes_left;
    current_song_next  = current_song;
    last_note_next     = last_note;
    generator_on_next  = generator_on;
    load               = 1'b0;
    if (mode) begin
      // An invalid song number keeps the old song and its remaining count.
      if (int'(song) < SONG_COUNT) begin
        current_song_next = song;
        notes_left_next   = SONG_LENGTH[song];
      end
      note_position_next = '0;
      phase_next         = PH_START;
    end else begin
      unique case (phase)
        PH_START: begin
          if (notes_left != '0) begin
            last_note_next    = entry[11:8];
            on_count_next     = TEMPO_TABLE[entry[7:4]];
            off_count_next    = TEMPO_TABLE[entry[3:0]];
            generator_on_next = 1'b1;
            load              = 1'b1;
            notes_left_next   = notes_left - 1'b1;
            phase_next        = PH_ON;
          end else begin
            generator_on_next = 1'b0;
            phase_next        = PH_IDLE;
          end
        end
        PH_ON: begin
          if (on_count != '0) begin
            on_count_next = on_count - 1'b1;
          end else begin
            phase_next = PH_OFF;
          end
        end
        PH_OFF: begin
          if (off_count != '0) begin
            off_count_next = off_count - 1'b1;
          end else begin
            if (note_position == PW'(MAX_NOTES - 1)) begin
              note_position_next = '0;
            end else begin
              note_position_next = note_position + 1'b1;
            end
            phase_next = PH_START;
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result of this item, taken from the state that it leaves.
  always_comb begin
    res.tone_gate    = (phase_next == PH_ON);
    res.note_code    = last_note_next;
    res.note_load    = load;
    res.tone_running = generator_on_next;
    res.busy_res     = (phase_next != PH_IDLE);
  end

  // Sequencer state, updated once for each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      on_count      <= '0;
      off_count     <= '0;
      note_position <= '0;
      notes_left    <= '0;
      current_song  <= '0;
      last_note     <= '0;
      generator_on  <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      on_count      <= on_count_next;
      off_count     <= off_count_next;
      note_position <= note_position_next;
      notes_left    <= notes_left_next;
      current_song  <= current_song_next;
      last_note     <= last_note_next;
      generator_on  <= generator_on_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/tms_out_reg.sv */
`default_nettype none

module tms_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire tms_pkg::tms_res_t res,
  output logic                   free,
  tms_out_if.source              rsp
);
  import tms_pkg::*;

  logic     valid;
  tms_res_t data;

  // Room for a new item when empty or when the held one leaves this cycle.
  assign free = !valid || rsp.ready;

  // Result register: holds its item until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data <= res;
    end
  end

  assign rsp.valid        = valid;
  assign rsp.tone_gate    = data.tone_gate;
  assign rsp.note_code    = data.note_code;
  assign rsp.note_load    = data.note_load;
  assign rsp.tone_running = data.tone_running;
  assign rsp.busy_res     = data.busy_res;

endmodule

`default_nettype wire

/* hw/rtl/tone_melody_sequencer_unit.sv */
`default_nettype none

// Melody sequencer for a buzzer: plays one of ten fixed melodies held in a
// constant note table.
// The req channel carries one item per command: mode 1 starts the song given
// in song (numbers ten and above restart the current song's position only),
// mode 0 is one sequencer tick. Each tick starts a note, counts down its
// on-time, counts down its off-time, moves on to the next note, or ends the song.
// The rsp channel returns exactly one item for each req item: tone gate,
// note code, a note load pulse for the tone generator, the generator run flag
// and a busy flag.
// The result is registered: an item accepted on req is shown on rsp in the
// cycle after. One item is accepted every cycle while the receiver does not
// stall; the note table read, the tempo lookup and the count decrement all
// sit in combinational logic before the result register.
// When the receiver stalls, the result register holds its item and req.ready
// drops, so no item is lost; req.ready rises again in the cycle rsp is taken.
// Synchronous reset puts the sequencer in idle with all counts, the song and
// the note cleared, and empties the result register.
module tone_melody_sequencer_unit #(
  parameter int MAX_NOTES = tms_pkg::MAX_NOTES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tms_in_if.sink    req,
  tms_out_if.source rsp
);
  import tms_pkg::*;

  logic     free;
  logic     accept;
  tms_res_t res;

  assign req.ready = free;
  assign accept    = req.valid && free;

  tms_core #(
    .MAX_NOTES (MAX_NOTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .mode   (req.mode),
    .song   (req.song),
    .res    (res)
  );

  tms_out_reg u_out (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .res  (res),
    .free (free),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire
